// ===== rtl/core/assert_macros.svh =====
// Assertion macros used by the filter top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent true implies consequent true in the same cycle.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Antecedent true implies consequent true in the next cycle.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/core/dmf_pkg.sv =====
// Types and constants of the duplicate message filter.
package dmf_pkg;

   localparam int unsigned MAX_SENDERS_DEFAULT = 16;

   localparam int unsigned NODE_W   = 32;
   localparam int unsigned TIME_W   = 64;
   localparam int unsigned WINDOW_W = 63;
   localparam int unsigned CSR_IDX_W = 8;

   localparam logic [WINDOW_W-1:0] DEFAULT_WINDOW = 63'd5000000000;

   localparam logic [CSR_IDX_W-1:0] CSR_OWN_NODE       = 8'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_RESTART_WINDOW = 8'd1;

   localparam logic [1:0] VERDICT_ACCEPT = 2'd0;
   localparam logic [1:0] VERDICT_OWN    = 2'd1;
   localparam logic [1:0] VERDICT_BADSUM = 2'd2;
   localparam logic [1:0] VERDICT_DUP    = 2'd3;

   // Search token handed from cell to cell.
   typedef struct packed {
      logic active;
      logic hit;
      logic dup;
   } probe_type;

   typedef enum logic [0:0] {
      ST_IDLE,
      ST_SCAN
   } state_type;

endpackage

// ===== rtl/core/dmf_cell.sv =====
// One table cell: holds a sender id and its last accepted timestamp, checks the passing token.
module dmf_cell (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                occupied,
   input  logic                                alloc_en,
   input  logic [dmf_pkg::NODE_W-1:0]          query_node,
   input  logic [dmf_pkg::TIME_W-1:0]          query_time,
   input  logic [dmf_pkg::WINDOW_W-1:0]        restart_window,
   input  dmf_pkg::probe_type                  probe_in,
   output dmf_pkg::probe_type                  probe_out
);
   import dmf_pkg::*;

   logic [NODE_W-1:0] id_ff;
   logic [NODE_W-1:0] id_in;
   logic [TIME_W-1:0] time_ff;
   logic [TIME_W-1:0] time_in;
   probe_type         probe_ff;
   probe_type         probe_in_next;

   logic              match;
   logic              not_newer;
   logic [TIME_W-1:0] step_back;
   logic              restarted;
   logic              is_dup;

   assign match     = probe_in.active && !probe_in.hit && occupied && (id_ff == query_node);
   assign not_newer = $signed(time_ff) >= $signed(query_time);
   assign step_back = time_ff - query_time;
   assign restarted = step_back > {1'b0, restart_window};
   assign is_dup    = not_newer && !restarted;

   always_comb begin
      id_in   = id_ff;
      time_in = time_ff;
      if (alloc_en) begin
         // a new sender always lands as accepted with its own timestamp
         id_in   = query_node;
         time_in = query_time;
      end else if (match && !is_dup) begin
         time_in = query_time;
      end
      probe_in_next.active = probe_in.active;
      probe_in_next.hit    = probe_in.hit | match;
      probe_in_next.dup    = match ? is_dup : probe_in.dup;
   end

   always_ff @(posedge clock) begin
      id_ff   <= id_in;
      time_ff <= time_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         probe_ff <= '0;
      end else begin
         probe_ff <= probe_in_next;
      end
   end

   assign probe_out = probe_ff;

endmodule

// ===== rtl/core/duplicate_message_filter_top.sv =====
// Top level of the duplicate message filter: control, registers and the cell chain.
//
//  channel | dir  | handshake            | payload
//  req     | in   | req_tvalid/tready    | tdata: sender_node, sent_time; tuser: checksum_ok
//  rsp     | out  | rsp_tvalid/tready    | tdata: verdict; tuser: table_full
//  csr     | in   | csr_valid/csr_ready  | csr_index, csr_data
//
// Own-node and bad-checksum items: the result is registered in the cycle after accept.
// Table lookups: a token walks the cell chain, one cell per cycle, and the result
// is registered once the token leaves the last cell; one item in flight at a time.
// Reset clears the sender count; table entries are filled as senders appear.
// A stalled result holds; the next item is taken as the result is taken.
module duplicate_message_filter_top #(
   parameter int unsigned MAX_SENDERS = dmf_pkg::MAX_SENDERS_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [95:0]                     req_tdata,  // [31:0] sender_node, [95:32] sent_time
   input  logic [0:0]                      req_tuser,  // [0] checksum_ok
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [7:0]                      rsp_tdata,  // [1:0] verdict, [7:2] zero
   output logic [0:0]                      rsp_tuser,  // [0] table_full
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [dmf_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [63:0]                     csr_data
);
   import dmf_pkg::*;
   `include "assert_macros.svh"

   localparam int unsigned CNT_W = $clog2(MAX_SENDERS + 1);
   localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_SENDERS);

   logic [NODE_W-1:0]   own_node_ff;
   logic [NODE_W-1:0]   own_node_in;
   logic [WINDOW_W-1:0] window_ff;
   logic [WINDOW_W-1:0] window_in;

   state_type           state_ff;
   state_type           state_in;
   logic [CNT_W-1:0]    count_ff;
   logic [CNT_W-1:0]    count_in;
   logic                start_ff;
   logic                start_in;
   logic [NODE_W-1:0]   q_node_ff;
   logic [NODE_W-1:0]   q_node_in;
   logic [TIME_W-1:0]   q_time_ff;
   logic [TIME_W-1:0]   q_time_in;

   logic                rsp_valid_ff;
   logic                rsp_valid_in;
   logic [1:0]          verdict_ff;
   logic [1:0]          verdict_in;
   logic                full_ff;
   logic                full_in;

   logic [NODE_W-1:0]   req_node;
   logic [TIME_W-1:0]   req_time;
   logic                req_accept;
   logic                is_own;
   logic                fast;
   logic                scan_start;
   logic                scan_done;
   logic                alloc;

   probe_type           chain [MAX_SENDERS+1];
   logic [MAX_SENDERS:0] token_vec;

   assign req_node = req_tdata[NODE_W-1:0];
   assign req_time = req_tdata[NODE_W +: TIME_W];
   assign is_own   = req_node == own_node_ff;
   assign fast     = is_own || !req_tuser[0];

   // configuration
   assign csr_ready = 1'b1;

   always_comb begin
      own_node_in = own_node_ff;
      window_in   = window_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_OWN_NODE:       own_node_in = csr_data[NODE_W-1:0];
            CSR_RESTART_WINDOW: window_in   = csr_data[WINDOW_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         own_node_ff <= '0;
         window_ff   <= DEFAULT_WINDOW;
      end else begin
         own_node_ff <= own_node_in;
         window_ff   <= window_in;
      end
   end

   // control
   assign scan_done  = chain[MAX_SENDERS].active;
   assign req_accept = req_tvalid && req_tready;

   always_comb begin
      state_in   = state_ff;
      req_tready = 1'b0;
      scan_start = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = !rsp_valid_ff || rsp_tready;
            if (req_tvalid && req_tready && !fast) begin
               scan_start = 1'b1;
               state_in   = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (scan_done) begin
               state_in = ST_IDLE;
            end
         end
      endcase
   end

   assign start_in  = scan_start;
   assign alloc     = scan_done && !chain[MAX_SENDERS].hit && (count_ff < CNT_MAX);
   assign count_in  = alloc ? count_ff + CNT_W'(1) : count_ff;
   assign q_node_in = req_accept ? req_node : q_node_ff;
   assign q_time_in = req_accept ? req_time : q_time_ff;

   // result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      verdict_in   = verdict_ff;
      full_in      = full_ff;
      if (req_accept && fast) begin
         rsp_valid_in = 1'b1;
         verdict_in   = is_own ? VERDICT_OWN : VERDICT_BADSUM;
         full_in      = 1'b0;
      end else if (scan_done) begin
         rsp_valid_in = 1'b1;
         if (chain[MAX_SENDERS].hit) begin
            verdict_in = chain[MAX_SENDERS].dup ? VERDICT_DUP : VERDICT_ACCEPT;
            full_in    = 1'b0;
         end else begin
            verdict_in = VERDICT_ACCEPT;
            full_in    = count_ff == CNT_MAX;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         start_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         start_ff     <= start_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      q_node_ff  <= q_node_in;
      q_time_ff  <= q_time_in;
      verdict_ff <= verdict_in;
      full_ff    <= full_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'b0, verdict_ff};
   assign rsp_tuser  = full_ff;

   // cell chain
   assign chain[0] = '{active: start_ff, hit: 1'b0, dup: 1'b0};

   for (genvar i = 0; i < MAX_SENDERS; i++) begin : g_cell
      dmf_cell u_cell (
         .clock          (clock),
         .reset          (reset),
         .occupied       (count_ff > CNT_W'(i)),
         .alloc_en       (alloc && (count_ff == CNT_W'(i))),
         .query_node     (q_node_ff),
         .query_time     (q_time_ff),
         .restart_window (window_ff),
         .probe_in       (chain[i]),
         .probe_out      (chain[i+1])
      );
   end

   for (genvar i = 0; i <= MAX_SENDERS; i++) begin : g_token
      assign token_vec[i] = chain[i].active;
   end

   // assertions
   `ASSERT_IMPLIES(a_count_bound, clock, reset, 1'b1, count_ff <= CNT_MAX,
      "sender count beyond table size")
   `ASSERT_IMPLIES(a_one_token, clock, reset, 1'b1, $onehot0(token_vec),
      "more than one token in the cell chain")
   `ASSERT_IMPLIES(a_scan_rsp_free, clock, reset, state_ff == ST_SCAN, !rsp_valid_ff,
      "result register busy during a table scan")
   `ASSERT_NEXT(a_hit_keeps_count, clock, reset, scan_done && chain[MAX_SENDERS].hit,
      $stable(count_ff), "known sender changed the sender count")

endmodule

// ===== tb/tb_duplicate_message_filter_top.sv =====
// Self-checking testbench for the duplicate message filter top level.
module tb_duplicate_message_filter_top;
   timeunit 1ns;
   timeprecision 1ps;

   import dmf_pkg::*;

   localparam int unsigned TABLE_DEPTH = MAX_SENDERS_DEFAULT;
   localparam int IDLE_LIMIT = 3000;
   localparam int PHASE_ITEMS = 190;
   localparam logic [63:0] MIN_TIME = 64'h8000_0000_0000_0000;
   localparam logic [63:0] MAX_TIME = 64'h7FFF_FFFF_FFFF_FFFF;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE = CSR_RESTART_WINDOW + 8'd1;

   typedef struct packed {
      logic [1:0] verdict;
      logic       table_full;
   } filter_result_type;

   typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE} rx_mode_type;
   typedef enum int {AGE_NEWER, AGE_SAME, AGE_WITHIN, AGE_AT_WINDOW, AGE_BEYOND} age_kind_type;

   logic                 clock;
   logic                 reset      = 1'b1;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [95:0]          req_tdata  = '0;  // [31:0] sender_node, [95:32] sent_time
   logic [0:0]           req_tuser  = '0;  // [0] checksum_ok
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [7:0]           rsp_tdata;        // [1:0] verdict, [7:2] zero
   logic [0:0]           rsp_tuser;        // [0] table_full
   logic                 csr_valid  = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index  = '0;
   logic [63:0]          csr_data   = '0;

   // Predictor state
   logic [31:0]          own_node_q = '0;
   logic [WINDOW_W-1:0]  window_q   = DEFAULT_WINDOW;
   logic [31:0]          node_tab [TABLE_DEPTH];
   logic [63:0]          seen_tab [TABLE_DEPTH];
   int unsigned          sender_count = 0;

   filter_result_type    pending_verdicts [$];
   filter_result_type    head_verdict;
   int                   mismatch_count = 0;
   int                   idle_cycles = 0;
   int                   burst_left = 0;
   bit                   sender_steady = 1'b0;
   rx_mode_type          rx_mode = RX_OPEN;
   int                   rx_run = 0;

   duplicate_message_filter_top #(.MAX_SENDERS(TABLE_DEPTH)) uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Verdict for one accepted message; updates the sender table.
   function automatic filter_result_type judge_message(input logic [31:0] node,
                                                       input logic [63:0] ts,
                                                       input logic ok);
      filter_result_type r;
      int slot;
      logic [63:0] last;
      r.verdict = VERDICT_ACCEPT;
      r.table_full = 1'b0;
      slot = -1;
      if (node == own_node_q) begin
         r.verdict = VERDICT_OWN;
         return r;
      end
      if (!ok) begin
         r.verdict = VERDICT_BADSUM;
         return r;
      end
      for (int i = 0; i < sender_count; i++)
         if (slot < 0 && node_tab[i] == node) slot = i;
      if (slot < 0) begin
         if (sender_count == TABLE_DEPTH) begin
            r.table_full = 1'b1;
            return r;
         end
         slot = sender_count;
         sender_count++;
         node_tab[slot] = node;
         seen_tab[slot] = ts - 64'd1;
      end
      last = seen_tab[slot];
      if ($signed(last) >= $signed(ts)) begin
         // stored time far ahead: sender restarted
         if ((last - ts) > {1'b0, window_q}) seen_tab[slot] = ts;
         else r.verdict = VERDICT_DUP;
      end else begin
         seen_tab[slot] = ts;
      end
      return r;
   endfunction

   task automatic report_mismatch(input string what, input logic [63:0] want,
                                  input logic [63:0] got);
      mismatch_count++;
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, what, want, got);
   endtask

   // Result checker
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_verdicts.size() == 0) begin
            report_mismatch("unexpected item", 64'd0, 64'({rsp_tuser, rsp_tdata}));
         end else begin
            head_verdict = pending_verdicts.pop_front();
            if (rsp_tdata !== {6'b0, head_verdict.verdict})
               report_mismatch("verdict", 64'({6'b0, head_verdict.verdict}),
                               64'(rsp_tdata));
            if (rsp_tuser[0] !== head_verdict.table_full)
               report_mismatch("table_full", 64'(head_verdict.table_full),
                               64'(rsp_tuser[0]));
         end
      end
   end

   // Receiver stalls in runs of varying style
   always @(negedge clock) begin
      if (rx_run == 0) begin
         rx_mode = rx_mode_type'($urandom_range(0, 2));
         rx_run = $urandom_range(8, 60);
      end
      rx_run--;
      case (rx_mode)
         RX_OPEN: rsp_tready <= 1'b1;
         RX_COIN: rsp_tready <= 1'($urandom_range(0, 1));
         default: rsp_tready <= ($urandom_range(0, 5) == 0);
      endcase
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("%0t: no handshake for %0d cycles", $time, IDLE_LIMIT);
         $display("tb_duplicate_message_filter_top: FAIL");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Leaves valid high after the accept; release_req, or a gap before the next send, drops it.
   task automatic send_message(input logic [31:0] node, input logic [63:0] ts,
                               input logic ok);
      int gap;
      gap = 0;
      if (!sender_steady) begin
         if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = $urandom_range(1, 20);
         end
         burst_left--;
      end
      if (gap > 0) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata  <= {ts, node};
      req_tuser  <= ok;
      do @(posedge clock); while (!req_tready);
      pending_verdicts.push_back(judge_message(node, ts, ok));
   endtask

   task automatic release_req();
      @(negedge clock);
      req_tvalid <= 1'b0;
   endtask

   task automatic drain();
      release_req();
      while (pending_verdicts.size() != 0) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] index, input logic [63:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      if (index == CSR_OWN_NODE) own_node_q = value[31:0];
      else if (index == CSR_RESTART_WINDOW) window_q = value[WINDOW_W-1:0];
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Own node beats a bad checksum, which beats the lookup.
   task automatic test_check_order();
      send_message(32'h0, 64'd0, 1'b0);
      send_message(32'h0, MAX_TIME, 1'b1);
      send_message(32'h1, 64'd7, 1'b0);
      send_message(32'hFFFF_FFFF, MIN_TIME, 1'b0);
      drain();
      write_csr(CSR_OWN_NODE, 64'hFFFF_FFFF);
      send_message(32'hFFFF_FFFF, 64'd3, 1'b1);
   endtask

   // New senders at the timestamp extremes, including the wrap at the minimum.
   task automatic test_new_sender_edges();
      send_message(32'h0, MIN_TIME, 1'b1);
      send_message(32'h0, MIN_TIME, 1'b1);
      send_message(32'h1234_5678, MAX_TIME, 1'b1);
      send_message(32'h1234_5678, MAX_TIME, 1'b1);
      send_message(32'h1234_5678, MIN_TIME, 1'b1);
      send_message(32'h1234_5678, MIN_TIME + 64'd1, 1'b1);
      send_message(32'h0000_0C0C, 64'd0, 1'b1);
      send_message(32'h0000_0C0C, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1);
   endtask

   // Step back equal to the window stays a duplicate; one more is a restart.
   task automatic test_restart_window();
      drain();
      write_csr(CSR_RESTART_WINDOW, 64'd100);
      send_message(32'h0000_0C0C, 64'd0 - 64'd100, 1'b1);
      send_message(32'h0000_0C0C, 64'd0 - 64'd101, 1'b1);
      send_message(32'h0000_0C0C, 64'd0 - 64'd100, 1'b1);
      drain();
      write_csr(CSR_RESTART_WINDOW, 64'd0);
      send_message(32'h0000_0C0C, 64'd0 - 64'd100, 1'b1);
      send_message(32'h0000_0C0C, 64'd0 - 64'd101, 1'b1);
      drain();
      // top bit is beyond the register and must be dropped
      write_csr(CSR_RESTART_WINDOW, 64'hFFFF_FFFF_FFFF_FFFF);
      send_message(32'h1234_5678, MAX_TIME, 1'b1);
      send_message(32'h1234_5678, MIN_TIME, 1'b1);
      send_message(32'h1234_5678, MAX_TIME, 1'b1);
      send_message(32'h1234_5678, 64'd0, 1'b1);
   endtask

   // A write past the register list must leave both registers alone.
   task automatic test_csr_spare_index();
      drain();
      write_csr(CSR_SPARE, 64'd0);
      send_message(32'h0000_0C0C, 64'd0 - 64'd102, 1'b1);
      send_message(32'h0, MIN_TIME + 64'd5, 1'b1);
   endtask

   task automatic send_random_message();
      logic [31:0] node;
      logic [63:0] ts;
      logic [63:0] last;
      logic [63:0] win;
      logic ok;
      int pick;
      int slot;
      node = $urandom;
      ts = {$urandom, $urandom};
      ok = 1'b1;
      pick = $urandom_range(0, 99);
      if (pick < 6) begin
         node = own_node_q;
         ok = 1'($urandom_range(0, 1));
      end else if (pick < 12) begin
         ok = 1'b0;
      end else if (pick >= 22) begin
         // known sender, timestamp placed around its stored time
         slot = $urandom_range(0, sender_count - 1);
         node = node_tab[slot];
         last = seen_tab[slot];
         win = {1'b0, window_q};
         case (age_kind_type'($urandom_range(0, 5)))
            AGE_SAME:      ts = last;
            AGE_WITHIN:    ts = last - $urandom_range(0, 40);
            AGE_AT_WINDOW: ts = last - win;
            AGE_BEYOND:    ts = last - win - 64'd1 - $urandom_range(0, 1000);
            default:       ts = last + $urandom_range(1, 100000);
         endcase
      end
      send_message(node, ts, ok);
   endtask

   task automatic test_random_traffic();
      logic [31:0] own;
      logic [63:0] win;
      for (int p = 0; p < 5; p++) begin
         drain();
         case (p)
            0: begin
               own = $urandom;
               win = {1'b0, DEFAULT_WINDOW};
            end
            1: begin
               own = 32'h0;
               win = $urandom_range(1, 5000);
            end
            2: begin
               own = $urandom;
               win = {$urandom, $urandom};
            end
            3: begin
               own = node_tab[$urandom_range(0, sender_count - 1)];
               win = 64'd0;
            end
            default: begin
               own = 32'hFFFF_FFFF;
               win = 64'h7FFF_FFFF_FFFF_FFFF;
            end
         endcase
         write_csr(CSR_OWN_NODE, {32'h0, own});
         write_csr(CSR_RESTART_WINDOW, win);
         sender_steady = (p == 2);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (n == PHASE_ITEMS / 2) drain();
            send_random_message();
         end
      end
      sender_steady = 1'b0;
   endtask

   initial begin
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_check_order();
      test_new_sender_edges();
      test_restart_window();
      test_csr_spare_index();
      test_random_traffic();

      drain();
      repeat (TABLE_DEPTH + 4) @(posedge clock);
      if (pending_verdicts.size() != 0)
         report_mismatch("leftover items", 64'd0, 64'(pending_verdicts.size()));
      if (mismatch_count == 0) begin
         $display("tb_duplicate_message_filter_top: PASS");
      end else begin
         $display("tb_duplicate_message_filter_top: FAIL");
      end
      $finish;
   end

endmodule
